### hw/rtl/nal_start_code_and_escape_inserter_unit_defines.svh
// Assertion macros used by the NAL framer's checker file.
// No dependencies; include by bare file name.
`ifndef NAL_START_CODE_AND_ESCAPE_INSERTER_UNIT_DEFINES_SVH
`define NAL_START_CODE_AND_ESCAPE_INSERTER_UNIT_DEFINES_SVH

// Assertion that is muted while the reset is asserted.
`define NSCEI_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define NSCEI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/nscei_pkg.sv
// Package for the NAL start code and escape inserter: types, byte codes
// and the start code lookup. No dependencies.
package nscei_pkg;

    typedef logic [7:0] byte_t;

    // Byte codes of the framed unit.
    localparam byte_t ZERO_BYTE       = 8'h00;
    localparam byte_t START_CODE_TAIL = 8'h01;
    localparam byte_t ESCAPE_BYTE     = 8'h03;
    localparam byte_t ESCAPE_LIMIT    = 8'h03;

    // Zero-run counter saturates at two.
    localparam logic [1:0] ZERO_SAT = 2'd2;

    // Start code length and the width of the prefix countdown.
    localparam int START_CODE_LEN = 4;
    localparam int PEND_W         = $clog2(START_CODE_LEN + 1);

    // Kind of prefix that goes in front of a payload byte.
    typedef enum logic [1:0] {
        PREFIX_NONE,
        PREFIX_START,
        PREFIX_ESCAPE
    } prefix_kind_t;

    // One byte handed to the output register.
    typedef struct packed {
        byte_t value;
        logic  last;
    } out_item_t;

    // Start code byte for a given number of remaining prefix bytes.
    function automatic byte_t start_code_byte(input logic [PEND_W-1:0] pend);
        byte_t result;
        result = (pend == PEND_W'(1)) ? START_CODE_TAIL : ZERO_BYTE;
        return result;
    endfunction

endpackage

### hw/rtl/nscei_in_if.sv
// Input channel of the NAL framer: one payload byte per transfer.
// Depends on nothing.
interface nscei_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### hw/rtl/nscei_out_if.sv
// Output channel of the NAL framer: one framed byte per transfer.
// Depends on nothing.
interface nscei_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### hw/rtl/nal_start_code_and_escape_inserter_unit.sv
// NAL start code and escape inserter: top level.
// Depends on nscei_pkg, nscei_in_if, nscei_out_if and nscei_out_stage.
//
// Usage: payload bytes arrive on the ingress channel, one per transfer, with
// last_byte set on the final byte of a unit. The egress channel gives the
// framed unit: the start code 00 00 00 01 before the first byte, an escape
// byte 03 before a byte of value 0 to 3 that follows two zero bytes (not on
// the final byte), then the payload byte; out_last follows last_byte.
// An accepted byte is held in the sequencer register; each of its output
// bytes then moves on into the output register, which offers it on egress.
// Throughput: one output byte per cycle from the single egress register while
// the receiver takes them; a byte gives one output byte, two with an escape,
// five when it opens a unit; the next byte is accepted in the cycle the
// current byte's payload byte moves on.
// Reset clears both registers and the framing state, so the first byte
// after reset opens a new unit. When the receiver stalls, the output register
// holds its byte, the sequencer waits and ingress.ready drops.
module nal_start_code_and_escape_inserter_unit (
    input  logic        clk,
    input  logic        rst_n,
    nscei_in_if.sink    ingress,
    nscei_out_if.source egress
);
    import nscei_pkg::*;

    // Framing state.
    logic              in_unit_reg, in_unit_next;
    logic [1:0]        zero_run_reg, zero_run_next;

    // Sequencer register: one payload byte and its pending prefix.
    logic              stage_valid_reg, stage_valid_next;
    byte_t             stage_byte_reg;
    logic              stage_last_reg;
    prefix_kind_t      stage_kind_reg, kind_new;
    logic [PEND_W-1:0] stage_pend_reg, stage_pend_next, pend_new;

    logic              accept;
    logic              emit;
    logic              stage_done;
    logic              out_ready;
    logic [1:0]        zero_run_base;
    logic              need_escape;
    out_item_t         cur_item;

    // Handshake between ingress, sequencer and output register.
    assign emit           = stage_valid_reg && out_ready;
    assign stage_done     = emit && (stage_pend_reg == '0);
    assign ingress.ready  = !stage_valid_reg || stage_done;
    assign accept         = ingress.valid && ingress.ready;

    // Decode the prefix of an incoming byte and the next framing state.
    always_comb
    begin
        zero_run_base = in_unit_reg ? zero_run_reg : 2'd0;
        need_escape   = (zero_run_base >= ZERO_SAT) && (ingress.data_byte <= ESCAPE_LIMIT)
                        && !ingress.last_byte;
        if (!in_unit_reg)
        begin
            kind_new = PREFIX_START;
            pend_new = PEND_W'(START_CODE_LEN);
        end
        else if (need_escape)
        begin
            kind_new = PREFIX_ESCAPE;
            pend_new = PEND_W'(1);
        end
        else
        begin
            kind_new = PREFIX_NONE;
            pend_new = '0;
        end

        in_unit_next  = in_unit_reg;
        zero_run_next = zero_run_reg;
        if (accept)
        begin
            if (ingress.last_byte)
            begin
                in_unit_next  = 1'b0;
                zero_run_next = 2'd0;
            end
            else
            begin
                in_unit_next = 1'b1;
                if (need_escape)
                begin
                    zero_run_next = (ingress.data_byte == ZERO_BYTE) ? 2'd1 : 2'd0;
                end
                else if (ingress.data_byte == ZERO_BYTE)
                begin
                    zero_run_next = (zero_run_base < ZERO_SAT) ? zero_run_base + 2'd1
                                                               : zero_run_base;
                end
                else
                begin
                    zero_run_next = 2'd0;
                end
            end
        end
    end

    // Sequencer control: load on a transfer, else clear when done or count down the prefix.
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_pend_next  = stage_pend_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
            stage_pend_next  = pend_new;
        end
        else if (stage_done)
        begin
            stage_valid_next = 1'b0;
        end
        else if (emit)
        begin
            stage_pend_next = stage_pend_reg - PEND_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_unit_reg     <= 1'b0;
            zero_run_reg    <= 2'd0;
            stage_valid_reg <= 1'b0;
            stage_pend_reg  <= '0;
        end
        else
        begin
            in_unit_reg     <= in_unit_next;
            zero_run_reg    <= zero_run_next;
            stage_valid_reg <= stage_valid_next;
            stage_pend_reg  <= stage_pend_next;
        end
    end

    // Payload of the sequencer register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= ingress.data_byte;
            stage_last_reg <= ingress.last_byte;
            stage_kind_reg <= kind_new;
        end
    end

    // Select the byte the sequencer offers this cycle.
    always_comb
    begin
        cur_item.value = stage_byte_reg;
        cur_item.last  = 1'b0;
        if (stage_pend_reg == '0)
        begin
            cur_item.last = stage_last_reg;
        end
        else
        begin
            unique case (stage_kind_reg)
                PREFIX_START:  cur_item.value = start_code_byte(stage_pend_reg);
                PREFIX_ESCAPE: cur_item.value = ESCAPE_BYTE;
                PREFIX_NONE:   cur_item.value = stage_byte_reg;
            endcase
        end
    end

    nscei_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (stage_valid_reg),
        .item       (cur_item),
        .item_ready (out_ready),
        .egress     (egress)
    );

endmodule

### hw/rtl/nscei_out_stage.sv
// Output register of the NAL framer; decouples the sequencer from stalls.
// Depends on nscei_pkg and nscei_out_if.
module nscei_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  nscei_pkg::out_item_t  item,
    output logic                  item_ready,
    nscei_out_if.source           egress
);
    import nscei_pkg::*;

    logic      valid_reg;
    out_item_t item_reg;
    logic      load;

    // The register takes a new byte when it is empty or its byte leaves now.
    assign item_ready = !valid_reg || egress.ready;
    assign load       = item_valid && item_ready;

    // Valid flag of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    // Payload of the output register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign egress.valid    = valid_reg;
    assign egress.out_byte = item_reg.value;
    assign egress.out_last = item_reg.last;

endmodule

### hw/rtl/nscei_checker.sv
// Port checker for the NAL framer, bound to the top level.
// Depends on nscei_pkg and the defines header.
`include "nal_start_code_and_escape_inserter_unit_defines.svh"

module nscei_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);
    import nscei_pkg::*;

    logic unit_open_reg;
    logic out_xfer;

    assign out_xfer = out_valid && out_ready;

    // Tracks whether the egress stream is inside a unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_open_reg <= 1'b0;
        end
        else if (out_xfer)
        begin
            unit_open_reg <= !out_last;
        end
    end

    // The output register is empty while reset is asserted.
    `NSCEI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid, "egress valid during reset")

    // A stalled output byte holds until it is taken.
    `NSCEI_ASSERT_RST(a_stall_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last),
        "egress byte changed while stalled")

    // Every unit opens with a zero byte of the start code and is not a lone last byte.
    `NSCEI_ASSERT_RST(a_unit_opens, clk, rst_n,
        out_xfer && !unit_open_reg |-> (out_byte == ZERO_BYTE) && !out_last,
        "unit does not open with the start code")

endmodule

bind nal_start_code_and_escape_inserter_unit nscei_checker u_nscei_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (egress.valid),
    .out_ready (egress.ready),
    .out_byte  (egress.out_byte),
    .out_last  (egress.out_last)
);

### tb/tb_nal_start_code_and_escape_inserter_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the NAL start code and escape inserter unit.
// Depends on nscei_pkg, nscei_in_if, nscei_out_if and the unit's top level.
module tb_nal_start_code_and_escape_inserter_unit;

    import nscei_pkg::*;

    // Run shape: the sender pauses before two items, the receiver holds off once.
    localparam int RANDOM_ITEMS = 290;
    localparam int PAUSE_A      = 60;
    localparam int PAUSE_B      = 220;
    localparam int HOLD_AT      = 140;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    // One stimulus row; n_typed nonzero means the results are spelled out in typed,
    // first result in typed[n_typed-1].
    typedef struct packed {
        byte_t       data;
        logic        fin;
        logic [2:0]  n_typed;
        byte_t [4:0] typed;
    } stim_row_t;

    logic clk;
    logic rst_n;

    nscei_in_if  in_ch ();
    nscei_out_if out_ch ();

    nal_start_code_and_escape_inserter_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .ingress (in_ch),
        .egress  (out_ch)
    );

    stim_row_t stim_q[$];
    out_item_t framed_q[$];
    out_item_t want;

    // Framing state mirrored by the predictor.
    logic       unit_open;
    logic [1:0] zero_count;

    logic hold_req;
    int   mismatches;
    int   bytes_sent;
    int   bytes_checked;
    int   units_sent;
    int   escapes_seen;
    int   idle_cycles;

    // The clock runs freely from time zero.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicts the framed bytes caused by one payload byte and advances the state.
    function automatic int frame_byte(input byte_t b, input logic fin,
                                      output out_item_t [4:0] res);
        int n;
        int k;
        n = 0;
        res = '0;
        if (!unit_open)
        begin
            for (k = 0; k < START_CODE_LEN; k++)
            begin
                res[n] = '{value: (k == START_CODE_LEN - 1) ? START_CODE_TAIL : ZERO_BYTE,
                           last: 1'b0};
                n++;
            end
            unit_open = 1'b1;
            zero_count = 2'd0;
        end
        if (zero_count >= ZERO_SAT && b <= ESCAPE_LIMIT && !fin)
        begin
            res[n] = '{value: ESCAPE_BYTE, last: 1'b0};
            n++;
            escapes_seen++;
            zero_count = (b == ZERO_BYTE) ? 2'd1 : 2'd0;
        end
        else if (b == ZERO_BYTE)
        begin
            if (zero_count < ZERO_SAT)
                zero_count = zero_count + 2'd1;
        end
        else
        begin
            zero_count = 2'd0;
        end
        res[n] = '{value: b, last: fin};
        n++;
        if (fin)
        begin
            unit_open = 1'b0;
            zero_count = 2'd0;
        end
        return n;
    endfunction

    task automatic add_row(input byte_t b, input logic fin, input logic [2:0] n_typed,
                           input byte_t [4:0] typed);
        stim_row_t row;
        row.data = b;
        row.fin = fin;
        row.n_typed = n_typed;
        row.typed = typed;
        stim_q.push_back(row);
    endtask

    // Random units: mostly short, zero-heavy payloads so escapes come often,
    // a few long ones and some fully random bytes.
    task automatic add_random_units(input int target);
        int    added;
        int    len;
        int    j;
        int    pick;
        byte_t b;
        added = 0;
        while (added < target)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            for (j = 0; j < len; j++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    b = ZERO_BYTE;
                else if (pick < 6)
                    b = byte_t'($urandom_range(1, 3));
                else
                    b = byte_t'($urandom);
                add_row(b, j == len - 1, 3'd0, '0);
            end
            added += len;
        end
    endtask

    // Receiver: stretches of full rate, random stalls and a fixed stall pattern,
    // with one long hold-off on request.
    initial
    begin
        int mode;
        int stretch;
        int phase;
        mode = 0;
        stretch = 0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode = $urandom_range(0, 2);
                    stretch = $urandom_range(10, 60);
                end
                stretch--;
                phase = (phase + 1) % 3;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= (phase != 0);
                endcase
            end
        end
    end

    // Each output transfer is checked against the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (framed_q.size() == 0)
            begin
                $display("%0t: output byte %h last %b with nothing expected",
                         $time, out_ch.out_byte, out_ch.out_last);
                mismatches++;
            end
            else
            begin
                want = framed_q.pop_front();
                if (want.value !== out_ch.out_byte)
                begin
                    $display("%0t: out_byte expected %h, got %h",
                             $time, want.value, out_ch.out_byte);
                    mismatches++;
                end
                if (want.last !== out_ch.out_last)
                begin
                    $display("%0t: out_last expected %b, got %b",
                             $time, want.last, out_ch.out_last);
                    mismatches++;
                end
                bytes_checked++;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sender: directed rows, then random units, in bursts with random gaps.
    initial
    begin
        stim_row_t        row;
        out_item_t [4:0]  res;
        int               n;
        int               k;
        int               idx;
        int               burst;

        clk = 1'b0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        out_ch.ready <= 1'b0;
        hold_req <= 1'b0;
        unit_open = 1'b0;
        zero_count = 2'd0;
        mismatches = 0;
        bytes_sent = 0;
        bytes_checked = 0;
        units_sent = 0;
        escapes_seen = 0;
        idle_cycles = 0;

        // Single-byte unit right after reset.
        add_row(8'hFF, 1'b1, 3'd5, {ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, START_CODE_TAIL, 8'hFF});
        // Escapes before 03, before a third zero and before 01; none before 04
        // or before a final 02.
        add_row(8'hAA, 1'b0, 3'd5, {ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, START_CODE_TAIL, 8'hAA});
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h03, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h01, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h04, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h02, 1'b1, 3'd0, '0);
        // Single zero byte as a whole unit.
        add_row(8'h00, 1'b1, 3'd5, {ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, START_CODE_TAIL, 8'h00});
        // A unit opening with zeros: the first byte is never escaped.
        add_row(8'h00, 1'b0, 3'd5, {ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, START_CODE_TAIL, 8'h00});
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h00, 1'b0, 3'd0, '0);
        add_row(8'h7F, 1'b0, 3'd0, '0);
        add_row(8'h80, 1'b1, 3'd0, '0);
        add_random_units(RANDOM_ITEMS);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        burst = $urandom_range(1, 40);
        for (idx = 0; idx < stim_q.size(); idx++)
        begin
            row = stim_q[idx];
            if (idx == PAUSE_A || idx == PAUSE_B)
            begin
                // Let every expected byte drain before going on.
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (framed_q.size() != 0)
                    @(posedge clk);
            end
            else if (burst == 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst = $urandom_range(1, 40);
            end
            if (idx == HOLD_AT)
                hold_req <= 1'b1;
            in_ch.valid <= 1'b1;
            in_ch.data_byte <= row.data;
            in_ch.last_byte <= row.fin;
            do
                @(posedge clk);
            while (!in_ch.ready);

            // The transfer took place at this edge.
            n = frame_byte(row.data, row.fin, res);
            if (row.n_typed != 0)
            begin
                for (k = int'(row.n_typed) - 1; k >= 0; k--)
                    framed_q.push_back('{value: row.typed[k],
                                         last: (k == 0) ? row.fin : 1'b0});
            end
            else
            begin
                for (k = 0; k < n; k++)
                    framed_q.push_back(res[k]);
            end
            if (row.fin)
                units_sent++;
            bytes_sent++;
            burst--;
        end
        in_ch.valid <= 1'b0;

        while (framed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Framed %0d units from %0d payload bytes, %0d escapes predicted.",
                 units_sent, bytes_sent, escapes_seen);
        $display("Checked %0d output bytes under bursty input and stalled output.",
                 bytes_checked);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
